[rtl/rse_pkg.sv]
// Package for the rectangle swap engine.
// Sizes, codes, request type and cell address helper; no dependencies.
package rse_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int DATA_W   = 32;
  localparam int FIELD_W  = 7;
  localparam int CMP_W    = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;
  localparam logic [FIELD_W-1:0]   DIM_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_SWAP  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_OVERLAP = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_SW_RD,
    S_SW_WP,
    S_SW_WQ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [FIELD_W-1:0] row_a;
    logic [FIELD_W-1:0] col_a;
    logic [FIELD_W-1:0] row_b;
    logic [FIELD_W-1:0] col_b;
    logic [FIELD_W-1:0] block_height;
    logic [FIELD_W-1:0] block_width;
    logic [DATA_W-1:0]  write_value;
  } req_t;

  // zero-based row and column to flat cell address
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [FIELD_W:0] row0,
                                                 input logic [FIELD_W:0] col0);
    logic [ADDR_W-1:0] r;
    logic [ADDR_W-1:0] c;
    r = ADDR_W'(row0);
    c = ADDR_W'(col0);
    return ADDR_W'(r * ADDR_W'(MAX_COLS)) + c;
  endfunction

endpackage

[rtl/rse_ram.sv]
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module rse_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [DATA_W-1:0] rdata0,
  output logic [DATA_W-1:0] rdata1
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

[rtl/rse_check.sv]
// Request checker: range and overlap test of a latched request.
// Depends on rse_pkg.
module rse_check (
  input  rse_pkg::req_t                 req,
  input  logic [rse_pkg::CMP_W-1:0]     lim_rows,
  input  logic [rse_pkg::CMP_W-1:0]     lim_cols,
  output rse_pkg::status_t              status
);
  import rse_pkg::*;

  function automatic logic span_ok(input logic [FIELD_W-1:0] first,
                                   input logic [FIELD_W-1:0] len,
                                   input logic [CMP_W-1:0] lim);
    logic [CMP_W-1:0] last;
    last = CMP_W'(first) + CMP_W'(len) - CMP_W'(1);
    return (first != '0) && (len != '0) && (last <= lim);
  endfunction

  logic [CMP_W-1:0] ra, rb, ca, cb, h, w;
  logic             cell_ok, swap_ok, rows_meet, cols_meet;

  always_comb begin
    ra = CMP_W'(req.row_a);
    rb = CMP_W'(req.row_b);
    ca = CMP_W'(req.col_a);
    cb = CMP_W'(req.col_b);
    h  = CMP_W'(req.block_height);
    w  = CMP_W'(req.block_width);
    cell_ok = span_ok(req.row_a, FIELD_W'(1), lim_rows) &&
              span_ok(req.col_a, FIELD_W'(1), lim_cols);
    swap_ok = span_ok(req.row_a, req.block_height, lim_rows) &&
              span_ok(req.row_b, req.block_height, lim_rows) &&
              span_ok(req.col_a, req.block_width, lim_cols) &&
              span_ok(req.col_b, req.block_width, lim_cols);
    rows_meet = (ra < rb + h) && (rb < ra + h);
    cols_meet = (ca < cb + w) && (cb < ca + w);
    unique case (req.op)
      OP_WRITE, OP_READ: status = cell_ok ? ST_OK : ST_RANGE;
      OP_SWAP: begin
        if (!swap_ok) begin
          status = ST_RANGE;
        end else if (rows_meet && cols_meet) begin
          status = ST_OVERLAP;
        end else begin
          status = ST_OK;
        end
      end
      default: status = ST_RANGE;
    endcase
  end

endmodule

[rtl/rectangle_swap_engine_top.sv]
// Rectangle swap engine top: request latch, sequencer, cell RAM, result register.
// Depends on rse_pkg, rse_ram, rse_check.
//
//   channel  dir  handshake            beat
//   in       in   in_valid / in_stall  op, corners, size, write_value
//   out      out  out_valid / out_stall read_value, status
//   cfg      in   cfg_wr_en            cfg_index, cfg_data
//
// One item at a time. Write or rejected item: S_CHECK, S_DONE; read: S_CHECK,
// S_READ, S_DONE; swap: S_CHECK, then S_SW_RD, S_SW_WP, S_SW_WQ per cell pair,
// then S_DONE (two-port read, then one write per cell on the single write port).
// rst is synchronous; it clears control state only, the cell RAM is not cleared.
// A stalled result waits in the output register; the next item is accepted
// meanwhile and holds in its final state until the register frees up.
module rectangle_swap_engine_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          op,
  input  logic [rse_pkg::FIELD_W-1:0]         row_a,
  input  logic [rse_pkg::FIELD_W-1:0]         col_a,
  input  logic [rse_pkg::FIELD_W-1:0]         row_b,
  input  logic [rse_pkg::FIELD_W-1:0]         col_b,
  input  logic [rse_pkg::FIELD_W-1:0]         block_height,
  input  logic [rse_pkg::FIELD_W-1:0]         block_width,
  input  logic signed [rse_pkg::DATA_W-1:0]   write_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rse_pkg::DATA_W-1:0]   read_value,
  output logic [1:0]                          status,
  input  logic                                cfg_wr_en,
  input  logic [rse_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rse_pkg::FIELD_W-1:0]         cfg_data
);
  import rse_pkg::*;

  state_t              state, state_next;
  req_t                req;
  logic [FIELD_W-1:0]  rows_in_use, cols_in_use;
  logic [CMP_W-1:0]    lim_rows, lim_cols;
  status_t             chk_status;
  logic [FIELD_W-1:0]  cnt_i, cnt_i_next, cnt_j, cnt_j_next;
  logic [DATA_W-1:0]   hold, hold_next;
  logic [DATA_W-1:0]   res_value, res_value_next;
  status_t             res_status, res_status_next;
  logic                load_out;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr0, ram_raddr1;
  logic [DATA_W-1:0]   ram_wdata, ram_rdata0, ram_rdata1;
  logic [ADDR_W-1:0]   addr_a, addr_p, addr_q;

  assign in_stall = (state != S_IDLE);

  assign lim_rows = (CMP_W'(rows_in_use) > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS)
                                                             : CMP_W'(rows_in_use);
  assign lim_cols = (CMP_W'(cols_in_use) > CMP_W'(MAX_COLS)) ? CMP_W'(MAX_COLS)
                                                             : CMP_W'(cols_in_use);

  assign addr_a = cell_addr({1'b0, req.row_a} - 8'd1, {1'b0, req.col_a} - 8'd1);
  assign addr_p = cell_addr({1'b0, req.row_a} - 8'd1 + {1'b0, cnt_i},
                            {1'b0, req.col_a} - 8'd1 + {1'b0, cnt_j});
  assign addr_q = cell_addr({1'b0, req.row_b} - 8'd1 + {1'b0, cnt_i},
                            {1'b0, req.col_b} - 8'd1 + {1'b0, cnt_j});

  rse_check u_check (
    .req      (req),
    .lim_rows (lim_rows),
    .lim_cols (lim_cols),
    .status   (chk_status)
  );

  rse_ram #(
    .DATA_W (DATA_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (ram_raddr0),
    .raddr1 (ram_raddr1),
    .rdata0 (ram_rdata0),
    .rdata1 (ram_rdata1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= DIM_RESET;
      cols_in_use <= DIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROWS: rows_in_use <= cfg_data;
        CFG_COLS: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt_i     <= '0;
      cnt_j     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt_i <= cnt_i_next;
      cnt_j <= cnt_j_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req.op           <= op;
      req.row_a        <= row_a;
      req.col_a        <= col_a;
      req.row_b        <= row_b;
      req.col_b        <= col_b;
      req.block_height <= block_height;
      req.block_width  <= block_width;
      req.write_value  <= write_value;
    end
    hold       <= hold_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
    if (load_out) begin
      read_value <= res_value;
      status     <= res_status;
    end
  end

  always_comb begin
    state_next      = state;
    cnt_i_next      = cnt_i;
    cnt_j_next      = cnt_j;
    hold_next       = hold;
    res_value_next  = res_value;
    res_status_next = res_status;
    load_out        = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = addr_p;
    ram_wdata       = ram_rdata1;
    ram_raddr0      = addr_p;
    ram_raddr1      = addr_q;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        res_status_next = chk_status;
        res_value_next  = '0;
        cnt_i_next      = '0;
        cnt_j_next      = '0;
        state_next      = S_DONE;
        if (chk_status == ST_OK) begin
          case (req.op)
            OP_WRITE: begin
              ram_we    = 1'b1;
              ram_waddr = addr_a;
              ram_wdata = req.write_value;
            end
            OP_READ: begin
              ram_raddr0 = addr_a;
              state_next = S_READ;
            end
            OP_SWAP: state_next = S_SW_RD;
            default: ;
          endcase
        end
      end
      S_READ: begin
        res_value_next = ram_rdata0;
        state_next     = S_DONE;
      end
      S_SW_RD: state_next = S_SW_WP;
      S_SW_WP: begin
        ram_we     = 1'b1;
        ram_waddr  = addr_p;
        ram_wdata  = ram_rdata1;
        hold_next  = ram_rdata0;
        state_next = S_SW_WQ;
      end
      S_SW_WQ: begin
        ram_we     = 1'b1;
        ram_waddr  = addr_q;
        ram_wdata  = hold;
        state_next = S_SW_RD;
        if (cnt_j == req.block_width - FIELD_W'(1)) begin
          cnt_j_next = '0;
          cnt_i_next = cnt_i + FIELD_W'(1);
          if (cnt_i == req.block_height - FIELD_W'(1)) begin
            state_next = S_DONE;
          end
        end else begin
          cnt_j_next = cnt_j + FIELD_W'(1);
        end
      end
      S_DONE: begin
        if (!(out_valid && out_stall)) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE || state == S_READ) |-> !ram_we)
    else $error("cell store written outside an active item");

  a_cnt_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SW_RD) |-> (cnt_i < req.block_height && cnt_j < req.block_width))
    else $error("swap counters past rectangle size");

  a_pair_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == S_SW_WQ) |-> (addr_p != addr_q))
    else $error("swap pair addresses coincide");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("result load did not raise out_valid");

  a_swap_only_ok: assert property (@(posedge clk) disable iff (rst)
    (state == S_SW_RD) |-> (res_status == ST_OK && req.op == OP_SWAP))
    else $error("swap sequence entered for a rejected item");
`endif

endmodule
